// ----- hdl/oll_pkg.sv -----
package oll_pkg;

    localparam int LIST_CAPACITY = 32;
    localparam int MAX_STREAM    = 32;
    localparam int STREAM_MAX    = (LIST_CAPACITY < MAX_STREAM) ? LIST_CAPACITY : MAX_STREAM;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = $clog2(LIST_CAPACITY);
    localparam int COUNT_W       = $clog2(LIST_CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_SEARCH = 3'd1,
        OP_MODIFY = 3'd2,
        OP_DELETE = 3'd3,
        OP_FWD    = 3'd4,
        OP_BWD    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic              tok_load;
        logic [IDX_W-1:0]  tok_idx;
        logic              tok_fwd;
        logic              tok_bwd;
        logic              step;
        logic              behind_set;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic              mod_en;
        logic              shift_en;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

// ----- hdl/oll_cell.sv -----
module oll_cell
    import oll_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [DATA_W-1:0] key,
    input  logic              prev_tok,
    input  logic              next_tok,
    input  logic [DATA_W-1:0] next_value,
    output logic              tok,
    output logic              match,
    output logic [DATA_W-1:0] value,
    output logic [DATA_W-1:0] tap
);

    logic [DATA_W-1:0] value_reg, value_next;
    logic              tok_reg, tok_next;
    logic              behind_reg, behind_next;
    logic              eq;

    assign eq    = (value_reg == key);
    assign tok   = tok_reg;
    assign match = tok_reg & eq;
    assign value = value_reg;
    assign tap   = tok_reg ? value_reg : '0;

    always_comb begin
        priority if (cmd.tok_load) begin
            tok_next = (cell_idx == cmd.tok_idx);
        end else if (cmd.tok_fwd) begin
            tok_next = prev_tok;
        end else if (cmd.tok_bwd) begin
            tok_next = next_tok;
        end else begin
            tok_next = tok_reg;
        end
    end

    // The behind flag marks cells at or after the scan position; a cell drops
    // it once the token has passed it without a match.
    always_comb begin
        priority if (cmd.behind_set) begin
            behind_next = 1'b1;
        end else if (cmd.step && tok_reg && !eq) begin
            behind_next = 1'b0;
        end else begin
            behind_next = behind_reg;
        end
    end

    always_comb begin
        priority if (cmd.wr_en && (cell_idx == cmd.wr_idx)) begin
            value_next = cmd.data;
        end else if (cmd.mod_en && tok_reg) begin
            value_next = cmd.data;
        end else if (cmd.shift_en && behind_reg) begin
            value_next = next_value;
        end else begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg    <= 1'b0;
            behind_reg <= 1'b0;
        end else begin
            tok_reg    <= tok_next;
            behind_reg <= behind_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ----- hdl/ordered_value_list_engine.sv -----
// Append, and any request that ends on an empty or full list, gives its single
// result by way of the S_RESPOND state. Search, modify and delete walk a token
// down the cell chain one entry per cycle. List requests stream one entry per
// cycle once the first entry is selected, as long as the output is not stalled.
// One request is worked on at a time; a new one is taken once the last result
// is in the output register. Reset empties the list; stored values are not cleared.
module ordered_value_list_engine
    import oll_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // search_key [31:0], new_value [63:32]
    input  logic [2:0]  s_tuser,   // operation [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // item_value [31:0]
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_STREAM,
        S_RESPOND
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [DATA_W-1:0]    key_reg, key_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    status_t              resp_reg, resp_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [DATA_W-1:0]    out_value_reg, out_value_next;
    logic                 out_last_reg, out_last_next;

    cell_cmd_t            cmd;
    logic [LIST_CAPACITY-1:0] tok;
    logic [LIST_CAPACITY-1:0] match;
    logic [DATA_W-1:0]    cell_value [LIST_CAPACITY];
    logic [DATA_W-1:0]    cell_tap [LIST_CAPACITY];
    logic [DATA_W-1:0]    tap_or;
    logic                 hit;
    logic                 can_emit;
    logic                 accept;
    op_t                  in_op;

    genvar g;
    generate
        for (g = 0; g < LIST_CAPACITY; g++) begin : g_cell
            logic              prev_tok_w;
            logic              next_tok_w;
            logic [DATA_W-1:0] next_value_w;
            if (g == 0) begin : g_head
                assign prev_tok_w = 1'b0;
            end else begin : g_mid
                assign prev_tok_w = tok[g-1];
            end
            if (g == LIST_CAPACITY - 1) begin : g_tail
                assign next_tok_w   = 1'b0;
                assign next_value_w = cell_value[g];
            end else begin : g_body
                assign next_tok_w   = tok[g+1];
                assign next_value_w = cell_value[g+1];
            end
            oll_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .cell_idx   (IDX_W'(g)),
                .key        (key_reg),
                .prev_tok   (prev_tok_w),
                .next_tok   (next_tok_w),
                .next_value (next_value_w),
                .tok        (tok[g]),
                .match      (match[g]),
                .value      (cell_value[g]),
                .tap        (cell_tap[g])
            );
        end
    endgenerate

    // Only the cell holding the token drives a nonzero tap.
    always_comb begin
        tap_or = '0;
        for (int i = 0; i < LIST_CAPACITY; i++) begin
            tap_or = tap_or | cell_tap[i];
        end
    end

    assign hit      = |match;
    assign can_emit = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        resp_next       = resp_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        cmd             = '0;
        cmd.data        = val_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next  = in_op;
                    key_next = s_tdata[31:0];
                    val_next = s_tdata[63:32];
                    idx_next = '0;
                    unique case (in_op)
                        OP_APPEND: begin
                            state_next = S_RESPOND;
                            if (count_reg == COUNT_W'(LIST_CAPACITY)) begin
                                resp_next = STAT_FULL;
                            end else begin
                                resp_next  = STAT_OK;
                                cmd.wr_en  = 1'b1;
                                cmd.wr_idx = count_reg[IDX_W-1:0];
                                cmd.data   = s_tdata[63:32];
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_SEARCH, OP_MODIFY, OP_DELETE: begin
                            if (count_reg == '0) begin
                                resp_next  = STAT_EMPTY;
                                state_next = S_RESPOND;
                            end else begin
                                cmd.tok_load   = 1'b1;
                                cmd.tok_idx    = '0;
                                cmd.behind_set = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        OP_FWD, OP_BWD: begin
                            if (count_reg == '0) begin
                                resp_next  = STAT_EMPTY;
                                state_next = S_RESPOND;
                            end else begin
                                cmd.tok_load = 1'b1;
                                cmd.tok_idx  = (in_op == OP_FWD) ? '0
                                             : IDX_W'(count_reg - COUNT_W'(1));
                                rem_next     = (count_reg > COUNT_W'(STREAM_MAX))
                                             ? COUNT_W'(STREAM_MAX) : count_reg;
                                state_next   = S_STREAM;
                            end
                        end
                        default: begin
                            // Unused operation codes are dropped without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                priority if (hit) begin
                    resp_next  = STAT_OK;
                    state_next = S_RESPOND;
                    if (op_reg == OP_MODIFY) begin
                        cmd.mod_en = 1'b1;
                    end else if (op_reg == OP_DELETE) begin
                        cmd.shift_en = 1'b1;
                        count_next   = count_reg - COUNT_W'(1);
                    end
                end else if (COUNT_W'(idx_reg) == count_reg - COUNT_W'(1)) begin
                    resp_next  = STAT_MISSING;
                    state_next = S_RESPOND;
                end else begin
                    cmd.tok_fwd = 1'b1;
                    cmd.step    = 1'b1;
                    idx_next    = idx_reg + IDX_W'(1);
                end
            end
            S_STREAM: begin
                if (can_emit) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_value_next  = tap_or;
                    out_last_next   = (rem_reg == COUNT_W'(1));
                    rem_next        = rem_reg - COUNT_W'(1);
                    cmd.tok_fwd     = (op_reg == OP_FWD);
                    cmd.tok_bwd     = (op_reg != OP_FWD);
                    if (rem_reg == COUNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESPOND: begin
                if (can_emit) begin
                    out_valid_next  = 1'b1;
                    out_status_next = resp_reg;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            idx_reg        <= idx_next;
            rem_reg        <= rem_next;
            resp_reg       <= resp_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

// ----- sim/list_checker.sv -----
module list_checker
    import oll_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // search_key [31:0], new_value [63:32]
    input  logic [2:0]  s_tuser,   // operation [2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // item_value [31:0]
    input  logic [1:0]  m_tuser,   // status [1:0]
    input  logic        m_tlast,
    output int          fail_count,
    output int          outstanding,
    output int          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic        last;
    } list_result_t;

    logic [31:0]  stored_vals [LIST_CAPACITY];
    int           stored_len;
    list_result_t pending_results [$];

    function automatic void queue_result(status_t st, logic [31:0] v, logic l);
        list_result_t r;
        r.status = st;
        r.value  = v;
        r.last   = l;
        pending_results.push_back(r);
    endfunction

    task automatic predict_request(input logic [2:0] op, input logic [31:0] key,
                                   input logic [31:0] val);
        int hit;
        int n;
        int i;
        hit = -1;
        case (op)
            OP_APPEND: begin
                if (stored_len >= LIST_CAPACITY) begin
                    queue_result(STAT_FULL, '0, 1'b1);
                end else begin
                    stored_vals[stored_len] = val;
                    stored_len++;
                    queue_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_SEARCH, OP_MODIFY, OP_DELETE: begin
                for (i = 0; i < stored_len; i++)
                    if (hit < 0 && stored_vals[i] == key)
                        hit = i;
                if (stored_len == 0) begin
                    queue_result(STAT_EMPTY, '0, 1'b1);
                end else if (hit < 0) begin
                    queue_result(STAT_MISSING, '0, 1'b1);
                end else begin
                    if (op == OP_MODIFY) begin
                        stored_vals[hit] = val;
                    end else if (op == OP_DELETE) begin
                        // Entries behind the removed one move up by one place.
                        for (i = hit; i + 1 < stored_len; i++)
                            stored_vals[i] = stored_vals[i + 1];
                        stored_len--;
                    end
                    queue_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_FWD, OP_BWD: begin
                if (stored_len == 0) begin
                    queue_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    n = (stored_len < MAX_STREAM) ? stored_len : MAX_STREAM;
                    for (i = 0; i < n; i++)
                        queue_result(STAT_OK,
                                     stored_vals[(op == OP_FWD) ? i : stored_len - 1 - i],
                                     i + 1 == n);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        list_result_t want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d item_value %h last_item %0b",
                   m_tuser, m_tdata, m_tlast);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            if (m_tuser !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, m_tuser);
                fail_count++;
            end
            if (m_tdata !== want.value) begin
                $error("item_value: expected %h, got %h", want.value, m_tdata);
                fail_count++;
            end
            if (m_tlast !== want.last) begin
                $error("last_item: expected %0b, got %0b", want.last, m_tlast);
                fail_count++;
            end
        end
        results_checked++;
    endtask

    // Results are handled before requests so that a request accepted on the
    // same edge can never satisfy an older result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            stored_len = 0;
            pending_results.delete();
        end else begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                check_result();
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
                predict_request(s_tuser, s_tdata[31:0], s_tdata[63:32]);
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- sim/testbench.sv -----
module testbench
    import oll_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_REQUESTS = 250;
    localparam int CYCLE_LIMIT     = 600000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int outstanding;
    int results_checked;

    int          cycle_count;
    int          burst_left;
    int          requests_sent;
    int          appends_refused;
    int          times_drained;
    int          round_idx;
    logic [31:0] held [$];

    ordered_value_list_engine u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    list_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles.", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // The receiver moves at random between four stall patterns.
    initial begin
        int mode;
        int hold;
        int tick;
        mode = 0;
        hold = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (tick % 64 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: begin
                    if (hold > 0) begin
                        hold--;
                        m_tready <= 1'b0;
                    end else begin
                        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                        m_tready <= 1'b1;
                    end
                end
                default: m_tready <= (tick % 3 != 0);
            endcase
        end
    end

    // Stimulus-side copy of the list contents, kept to aim keys at entries that
    // are present and to know when the list is full or empty.
    function automatic void note_request(logic [2:0] op, logic [31:0] key, logic [31:0] val);
        int hit;
        hit = -1;
        foreach (held[i])
            if (hit < 0 && held[i] == key)
                hit = i;
        case (op)
            OP_APPEND: begin
                if (held.size() < LIST_CAPACITY)
                    held.push_back(val);
                else
                    appends_refused++;
            end
            OP_MODIFY: if (hit >= 0) held[hit] = val;
            OP_DELETE: if (hit >= 0) held.delete(hit);
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // A narrow band of values makes duplicate entries common.
                v = $urandom_range(0, 8);
                v = v - 32'd4;
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_key();
        if (held.size() > 0 && $urandom_range(0, 3) != 0)
            return held[$urandom_range(0, held.size() - 1)];
        return pick_value();
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [31:0] key,
                                input logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(20, 40);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 10);
                gap = $urandom_range(1, 6);
            end
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        do @(posedge aclk); while (s_tready !== 1'b1);
        note_request(op, key, val);
        if (op <= OP_BWD)
            requests_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic mixed_round(input int count, input int append_pct);
        int r;
        logic [2:0] op;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < append_pct)
                op = OP_APPEND;
            else
                case ($urandom_range(0, 10))
                    0, 1: op = OP_SEARCH;
                    2, 3, 4: op = OP_MODIFY;
                    5, 6, 7: op = OP_DELETE;
                    8: op = OP_FWD;
                    9: op = OP_BWD;
                    default: op = 3'($urandom_range(6, 7));
                endcase
            send_request(op, pick_key(), pick_value());
        end
    endtask

    initial begin
        burst_left      = 0;
        requests_sent   = 0;
        appends_refused = 0;
        times_drained   = 0;
        round_idx       = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty list cases, then the lone entry deleted.
        send_request(OP_FWD,    $urandom, $urandom);
        send_request(OP_BWD,    $urandom, $urandom);
        send_request(OP_SEARCH, 32'h0000_0000, $urandom);
        send_request(OP_MODIFY, 32'hffff_ffff, 32'h1234_5678);
        send_request(OP_DELETE, 32'h8000_0000, $urandom);
        send_request(OP_APPEND, $urandom, 32'h7fff_ffff);
        send_request(OP_DELETE, 32'h7fff_ffff, $urandom);
        send_request(OP_FWD,    $urandom, $urandom);
        send_request(OP_APPEND, $urandom, 32'h8000_0000);
        send_request(OP_APPEND, $urandom, 32'h0000_0000);
        send_request(OP_APPEND, $urandom, 32'hffff_ffff);
        send_request(OP_APPEND, $urandom, 32'h0000_0000);
        send_request(OP_APPEND, $urandom, 32'h7fff_ffff);
        send_request(OP_SEARCH, 32'h0000_0000, $urandom);
        send_request(OP_SEARCH, 32'h0001_2345, $urandom);
        // The first of the two zero entries is the one replaced.
        send_request(OP_MODIFY, 32'h0000_0000, 32'h5555_aaaa);
        send_request(OP_MODIFY, 32'h0bad_cafe, 32'haaaa_5555);
        send_request(OP_DELETE, 32'h0bad_cafe, $urandom);
        send_request(OP_DELETE, 32'h8000_0000, $urandom);
        send_request(OP_DELETE, 32'h7fff_ffff, $urandom);
        send_request(OP_FWD,    $urandom, $urandom);
        send_request(OP_BWD,    $urandom, $urandom);
        send_request(3'd6, 32'hffff_ffff, 32'hffff_ffff);
        send_request(3'd7, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_SEARCH, 32'hffff_ffff, $urandom);

        while (requests_sent < TARGET_REQUESTS) begin
            case (round_idx % 5)
                0: mixed_round(30, 45);
                1: begin
                    while (held.size() < LIST_CAPACITY)
                        send_request(OP_APPEND, $urandom, pick_value());
                    send_request(OP_APPEND, $urandom, pick_value());
                    send_request(OP_APPEND, $urandom, pick_value());
                    send_request(OP_FWD, $urandom, $urandom);
                    send_request(OP_BWD, $urandom, $urandom);
                    hold_until_drained();
                end
                2: mixed_round(30, 20);
                3: begin
                    while (held.size() > 0)
                        send_request(OP_DELETE, held[$urandom_range(0, held.size() - 1)],
                                     pick_value());
                    times_drained++;
                    send_request(OP_DELETE, pick_value(), pick_value());
                    send_request(OP_BWD, $urandom, $urandom);
                end
                default: begin
                    repeat (10)
                        send_request(3'($urandom_range(0, 7)), $urandom, $urandom);
                end
            endcase
            round_idx++;
        end

        hold_until_drained();
        repeat (LIST_CAPACITY + 8) @(negedge aclk);

        $display("Sent %0d list requests over %0d rounds; %0d results compared.",
                 requests_sent, round_idx, results_checked);
        $display("Appends refused on a full list: %0d; list emptied by deletes %0d times.",
                 appends_refused, times_drained);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/oll_pkg.sv
hdl/oll_cell.sv
hdl/ordered_value_list_engine.sv
sim/list_checker.sv
sim/testbench.sv
